// File: sv/vlb_pkg.sv
// Shared types and constants for the video line buffer with burst prefetch.
// Holds the classified timing item, the result item and the fetch state type.
// No dependencies.
package vlb_pkg;

   // Fixed data widths.
   localparam int WORD_BITS       = 64;
   localparam int NUM_LINE_STORES = 4;
   localparam int STORE_SEL_BITS  = 2;
   localparam int PIXEL_BITS      = 16;
   localparam int ROW_BITS        = 11;
   localparam int COLUMN_BITS     = 12;
   localparam int FILL_BITS       = 9;
   localparam int ADDRESS_BITS    = 24;
   localparam int PHASE_BITS      = 4;
   localparam int DE_DELAY_BITS   = 4;
   localparam int SYNC_DELAY_BITS = 2;

   // Fixed values.
   localparam logic [FILL_BITS-1:0]   FILL_LOW_MARK = 9'd96;
   localparam logic [COLUMN_BITS-1:0] COLUMN_STEP   = 12'd4;
   localparam logic [COLUMN_BITS-1:0] WIDTH_RESET   = 12'd639;
   localparam logic [PHASE_BITS-1:0]  PHASE_FIRST   = 4'b0001;

   // Fetch engine states.
   typedef enum logic [1:0] {
      FETCH_IDLE,
      FETCH_REQUEST,
      FETCH_WRITING,
      FETCH_END_FRAME
   } fetch_state_type;

   // One classified sample of timing and memory handshakes.
   typedef struct packed {
      logic                 hsync_out;
      logic                 vsync_out;
      logic                 de_out;
      logic                 vsync;
      logic                 vsync_rise;
      logic                 hsync_fall;
      logic                 de;
      logic                 de_prev;
      logic                 de_quiet;
      logic                 mem_ready;
      logic                 resp_valid;
      logic                 resp_last;
      logic [WORD_BITS-1:0] resp_word;
   } item_type;

   // One result of a pixel clock step.
   typedef struct packed {
      logic                    hsync_out;
      logic                    vsync_out;
      logic                    de_out;
      logic [PIXEL_BITS-1:0]   pixel_rgb565;
      logic                    burst_request;
      logic [ADDRESS_BITS-1:0] req_address;
      logic                    word_accept;
   } result_type;

endpackage

// File: sv/video_line_buffer_fetch_and_scanout_top.sv
// Video line buffer with burst prefetch and scan-out, top level.
// A sample is registered in the middle queue, and its result in the result queue, before it can be popped.
// Throughput: one sample per cycle while the result queue has room, set by the back end taking one step
// per item with one access per line store port.
// Reset is synchronous: queues and control state clear, row width minus one becomes 639;
// line store contents are not cleared. Depends on vlb_pkg, vlb_front, vlb_queue, vlb_back.
module video_line_buffer_fetch_and_scanout_top #(
   parameter int LINE_ADDR_BITS = 6,
   parameter int QUEUE_DEPTH    = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [vlb_pkg::COLUMN_BITS-1:0]  csr_write_data,
   input  logic                             push,
   output logic                             full,
   input  logic                             req_hsync_in,
   input  logic                             req_vsync_in,
   input  logic                             req_de_in,
   input  logic                             req_req_ready,
   input  logic                             req_resp_valid,
   input  logic                             req_resp_last,
   input  logic [vlb_pkg::WORD_BITS-1:0]    req_resp_word,
   output logic                             empty,
   input  logic                             pop,
   output logic                             rsp_hsync_out,
   output logic                             rsp_vsync_out,
   output logic                             rsp_de_out,
   output logic [vlb_pkg::PIXEL_BITS-1:0]   rsp_pixel_rgb565,
   output logic                             rsp_burst_request,
   output logic [vlb_pkg::ADDRESS_BITS-1:0] rsp_req_address,
   output logic                             rsp_word_accept
);

   localparam int ITEM_BITS   = $bits(vlb_pkg::item_type);
   localparam int RESULT_BITS = $bits(vlb_pkg::result_type);

   logic                mid_push;
   logic                mid_full;
   logic                mid_empty;
   vlb_pkg::item_type   front_item;
   logic [ITEM_BITS-1:0] mid_data;
   vlb_pkg::item_type   back_item;
   logic                step;
   logic                out_full;
   vlb_pkg::result_type back_result;
   logic [RESULT_BITS-1:0] out_data;
   vlb_pkg::result_type out_result;

   // Front end: classify samples.
   vlb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .hsync_in   (req_hsync_in),
      .vsync_in   (req_vsync_in),
      .de_in      (req_de_in),
      .mem_ready  (req_req_ready),
      .resp_valid (req_resp_valid),
      .resp_last  (req_resp_last),
      .resp_word  (req_resp_word),
      .queue_full (mid_full),
      .queue_push (mid_push),
      .queue_item (front_item)
   );

   // Queue between the front and back ends.
   vlb_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (step),
      .empty     (mid_empty),
      .pop_data  (mid_data)
   );

   assign back_item = vlb_pkg::item_type'(mid_data);

   // Back end: one pixel clock step per item.
   vlb_back #(
      .LINE_ADDR_BITS (LINE_ADDR_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (!mid_empty),
      .item             (back_item),
      .result_full      (out_full),
      .step             (step),
      .result           (back_result)
   );

   // Result queue toward the consumer.
   vlb_queue #(
      .WIDTH (RESULT_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (back_result),
      .full      (out_full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (out_data)
   );

   assign out_result        = vlb_pkg::result_type'(out_data);
   assign rsp_hsync_out     = out_result.hsync_out;
   assign rsp_vsync_out     = out_result.vsync_out;
   assign rsp_de_out        = out_result.de_out;
   assign rsp_pixel_rgb565  = out_result.pixel_rgb565;
   assign rsp_burst_request = out_result.burst_request;
   assign rsp_req_address   = out_result.req_address;
   assign rsp_word_accept   = out_result.word_accept;

   // An accepted sample is waiting for the back end in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> !mid_empty)
      else $error("accepted sample missing from the middle queue");

   // A back end step always leaves a result to be taken.
   assert property (@(posedge clock) disable iff (reset)
      step |=> !empty)
      else $error("result of a back end step is missing");

endmodule

// File: sv/vlb_ram.sv
// Generic single-port RAM with registered, write-first read.
// Used for the line stores. No dependencies.
module vlb_ram #(
   parameter int DATA_WIDTH = 64,
   parameter int DEPTH      = 64
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [DATA_WIDTH-1:0]    write_data,
   output logic [DATA_WIDTH-1:0]    read_data
);

   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] read_data_ff;

   // Write and read share one port; a write also loads the registered read data.
   always_ff @(posedge clock) begin
      if (enable) begin
         if (write_enable) begin
            store_ff[address] <= write_data;
            read_data_ff      <= write_data;
         end else begin
            read_data_ff <= store_ff[address];
         end
      end
   end

   assign read_data = read_data_ff;

endmodule

// File: sv/vlb_queue.sv
// Small register queue with separate push and pop sides.
// Depth must be a power of two of at least two. No dependencies.
module vlb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   write_ptr_ff, write_ptr_in;
   logic [PTR_BITS-1:0]   read_ptr_ff, read_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  push_fire;
   logic                  pop_fire;

   assign full      = (count_ff == COUNT_BITS'(DEPTH));
   assign empty     = (count_ff == '0);
   assign push_fire = push && !full;
   assign pop_fire  = pop && !empty;
   assign pop_data  = slot_ff[read_ptr_ff];

   // Pointer and occupancy update for each transfer.
   always_comb begin
      write_ptr_in = write_ptr_ff;
      read_ptr_in  = read_ptr_ff;
      count_in     = count_ff;
      if (push_fire) begin
         write_ptr_in = write_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         read_ptr_in = read_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (!push_fire && pop_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff <= '0;
         read_ptr_ff  <= '0;
         count_ff     <= '0;
      end else begin
         write_ptr_ff <= write_ptr_in;
         read_ptr_ff  <= read_ptr_in;
         count_ff     <= count_in;
      end
   end

   // Payload slots need no reset.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[write_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/vlb_front.sv
// Front end: takes timing and handshake samples and classifies them.
// Tracks the sync and data enable history and finds their edges.
// Depends on vlb_pkg.
module vlb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          hsync_in,
   input  logic                          vsync_in,
   input  logic                          de_in,
   input  logic                          mem_ready,
   input  logic                          resp_valid,
   input  logic                          resp_last,
   input  logic [vlb_pkg::WORD_BITS-1:0] resp_word,
   input  logic                          queue_full,
   output logic                          queue_push,
   output vlb_pkg::item_type             queue_item
);

   logic [vlb_pkg::SYNC_DELAY_BITS-1:0] hsync_delay_ff, hsync_delay_in;
   logic [vlb_pkg::SYNC_DELAY_BITS-1:0] vsync_delay_ff, vsync_delay_in;
   logic [vlb_pkg::DE_DELAY_BITS-1:0]   de_delay_ff, de_delay_in;
   logic                                accept;

   assign full       = queue_full;
   assign accept     = push && !queue_full;
   assign queue_push = accept;

   // Shift the new sample into each history.
   assign hsync_delay_in = {hsync_delay_ff[vlb_pkg::SYNC_DELAY_BITS-2:0], hsync_in};
   assign vsync_delay_in = {vsync_delay_ff[vlb_pkg::SYNC_DELAY_BITS-2:0], vsync_in};
   assign de_delay_in    = {de_delay_ff[vlb_pkg::DE_DELAY_BITS-2:0], de_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         hsync_delay_ff <= '0;
         vsync_delay_ff <= '0;
         de_delay_ff    <= '0;
      end else if (accept) begin
         hsync_delay_ff <= hsync_delay_in;
         vsync_delay_ff <= vsync_delay_in;
         de_delay_ff    <= de_delay_in;
      end
   end

   // Classify the sample against the history held before this transfer.
   always_comb begin
      queue_item            = '0;
      queue_item.hsync_out  = hsync_delay_ff[1];
      queue_item.vsync_out  = vsync_delay_ff[1];
      queue_item.de_out     = de_delay_ff[1];
      queue_item.vsync      = vsync_in;
      queue_item.vsync_rise = vsync_in && !vsync_delay_ff[0];
      queue_item.hsync_fall = !hsync_in && hsync_delay_ff[0];
      queue_item.de         = de_in;
      queue_item.de_prev    = de_delay_ff[0];
      queue_item.de_quiet   = (de_delay_ff == '0);
      queue_item.mem_ready  = mem_ready;
      queue_item.resp_valid = resp_valid;
      queue_item.resp_last  = resp_last;
      queue_item.resp_word  = resp_word;
   end

endmodule

// File: sv/vlb_back.sv
// Back end: fetch engine, line stores and pixel scan-out, one step per item.
// Owns the row width register and the four line store RAMs.
// Depends on vlb_pkg and vlb_ram.
module vlb_back #(
   parameter int LINE_ADDR_BITS = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [vlb_pkg::COLUMN_BITS-1:0] csr_write_data,
   input  logic                            item_valid,
   input  vlb_pkg::item_type               item,
   input  logic                            result_full,
   output logic                            step,
   output vlb_pkg::result_type             result
);

   localparam int PTR_BITS   = LINE_ADDR_BITS + 2;
   localparam int LINE_WORDS = 1 << LINE_ADDR_BITS;

   logic [vlb_pkg::COLUMN_BITS-1:0]     width_minus_one_ff;
   logic [vlb_pkg::ROW_BITS-1:0]        write_row_ff, write_row_in;
   logic [vlb_pkg::COLUMN_BITS-1:0]     write_column_ff, write_column_in;
   logic [PTR_BITS-1:0]                 write_pointer_ff, write_pointer_in;
   logic [PTR_BITS-1:0]                 read_pointer_ff, read_pointer_in;
   logic [vlb_pkg::PHASE_BITS-1:0]      word_phase_ff, word_phase_in;
   logic [vlb_pkg::NUM_LINE_STORES-1:0] store_select_ff;
   logic [vlb_pkg::PHASE_BITS-1:0]      pixel_select_ff;
   logic [vlb_pkg::FILL_BITS-1:0]       fill_count_ff, fill_count_in;
   vlb_pkg::fetch_state_type            fetch_state_ff, fetch_state_in;
   logic [vlb_pkg::ADDRESS_BITS-1:0]    request_address_ff, request_address_in;
   logic                                request_pending_ff, request_pending_in;
   logic                                response_accept_ff, response_accept_in;
   logic [vlb_pkg::PIXEL_BITS-1:0]      pixel_ff, pixel_in;
   logic                                read_enable;
   logic [vlb_pkg::WORD_BITS-1:0]       store_data [vlb_pkg::NUM_LINE_STORES];
   logic [vlb_pkg::WORD_BITS-1:0]       picked_word;
   logic [vlb_pkg::STORE_SEL_BITS-1:0]  write_store;

   // First pointer of the line store after the one the pointer is in.
   function automatic logic [PTR_BITS-1:0] line_start_after(input logic [PTR_BITS-1:0] ptr);
      logic [vlb_pkg::STORE_SEL_BITS-1:0] sel;
      sel = ptr[PTR_BITS-1 -: vlb_pkg::STORE_SEL_BITS] + 1'b1;
      return {sel, {LINE_ADDR_BITS{1'b0}}};
   endfunction

   assign step        = item_valid && !result_full;
   assign write_store = write_pointer_ff[PTR_BITS-1 -: vlb_pkg::STORE_SEL_BITS];

   // Results come from the state held before this step.
   always_comb begin
      result               = '0;
      result.hsync_out     = item.hsync_out;
      result.vsync_out     = item.vsync_out;
      result.de_out        = item.de_out;
      result.pixel_rgb565  = pixel_ff;
      result.burst_request = request_pending_ff;
      result.req_address   = request_address_ff;
      result.word_accept   = response_accept_ff;
   end

   // Fetch engine, read side and fill count.
   always_comb begin
      write_row_in       = write_row_ff;
      write_column_in    = write_column_ff;
      write_pointer_in   = write_pointer_ff;
      read_pointer_in    = read_pointer_ff;
      word_phase_in      = word_phase_ff;
      fill_count_in      = fill_count_ff;
      fetch_state_in     = fetch_state_ff;
      request_address_in = request_address_ff;
      request_pending_in = request_pending_ff;
      response_accept_in = response_accept_ff;
      read_enable        = 1'b0;

      // A vsync rise enters end of frame unless the engine moves on in this same step.
      if (item.vsync_rise) begin
         fetch_state_in = vlb_pkg::FETCH_END_FRAME;
      end

      case (fetch_state_ff)
         vlb_pkg::FETCH_IDLE: begin
            if (fill_count_ff[vlb_pkg::FILL_BITS-1] ||
                fill_count_ff <= vlb_pkg::FILL_LOW_MARK) begin
               request_pending_in = 1'b1;
               request_address_in = {write_row_ff, write_column_ff, 1'b0};
               fetch_state_in     = vlb_pkg::FETCH_REQUEST;
            end
         end
         vlb_pkg::FETCH_REQUEST: begin
            request_pending_in = 1'b1;
            response_accept_in = 1'b0;
            if (request_pending_ff && item.mem_ready) begin
               request_pending_in = 1'b0;
               response_accept_in = 1'b1;
               fetch_state_in     = vlb_pkg::FETCH_WRITING;
            end
         end
         vlb_pkg::FETCH_WRITING: begin
            if (item.resp_valid) begin
               write_column_in  = write_column_ff + vlb_pkg::COLUMN_STEP;
               write_pointer_in = write_pointer_ff + 1'b1;
               if (item.resp_last) begin
                  response_accept_in = 1'b0;
                  fetch_state_in     = vlb_pkg::FETCH_IDLE;
                  // The last burst of a row moves to the next line store.
                  if (write_column_ff >= width_minus_one_ff) begin
                     write_column_in  = '0;
                     write_row_in     = write_row_ff + 1'b1;
                     write_pointer_in = line_start_after(write_pointer_ff);
                  end
               end
            end
         end
         default: begin
            // End of frame: wait for vsync low, then restart the write and read positions, fill count and word phase.
            if (!item.vsync) begin
               write_column_in  = '0;
               write_row_in     = '0;
               write_pointer_in = '0;
               fill_count_in    = '0;
               read_pointer_in  = '0;
               word_phase_in    = vlb_pkg::PHASE_FIRST;
               fetch_state_in   = vlb_pkg::FETCH_IDLE;
            end
         end
      endcase

      // Read side: one word every four visible pixels, next line on enable fall.
      if (item.de) begin
         word_phase_in = {word_phase_ff[vlb_pkg::PHASE_BITS-2:0],
                          word_phase_ff[vlb_pkg::PHASE_BITS-1]};
         if (word_phase_ff[0]) begin
            read_enable     = 1'b1;
            read_pointer_in = read_pointer_ff + 1'b1;
         end
      end else if (item.de_prev) begin
         read_pointer_in = line_start_after(read_pointer_ff);
         word_phase_in   = vlb_pkg::PHASE_FIRST;
      end

      // Fill count tracks words fetched minus words read, reloaded from the write column on an hsync fall.
      if (item.resp_valid && !read_enable) begin
         fill_count_in = fill_count_ff + 1'b1;
      end else if (!item.resp_valid && read_enable) begin
         fill_count_in = fill_count_ff - 1'b1;
      end else if (item.hsync_fall) begin
         fill_count_in = write_column_ff[vlb_pkg::FILL_BITS+1:2];
      end
   end

   // Pixel pick from the words read in the previous step.
   always_comb begin
      if (store_select_ff[0]) begin
         picked_word = store_data[0];
      end else if (store_select_ff[1]) begin
         picked_word = store_data[1];
      end else if (store_select_ff[2]) begin
         picked_word = store_data[2];
      end else begin
         picked_word = store_data[3];
      end
      if (item.de_quiet) begin
         pixel_in = '0;
      end else if (pixel_select_ff[0]) begin
         pixel_in = picked_word[15:0];
      end else if (pixel_select_ff[1]) begin
         pixel_in = picked_word[31:16];
      end else if (pixel_select_ff[2]) begin
         pixel_in = picked_word[47:32];
      end else begin
         pixel_in = picked_word[63:48];
      end
   end

   // Line stores: the store being filled works at the write pointer,
   // the others at the read pointer.
   for (genvar k = 0; k < vlb_pkg::NUM_LINE_STORES; k++) begin : g_store
      logic                            is_write_store;
      logic [LINE_ADDR_BITS-1:0]       store_address;

      assign is_write_store = (write_store == vlb_pkg::STORE_SEL_BITS'(k));
      assign store_address  = is_write_store ? write_pointer_ff[LINE_ADDR_BITS-1:0]
                                             : read_pointer_ff[LINE_ADDR_BITS-1:0];

      vlb_ram #(
         .DATA_WIDTH (vlb_pkg::WORD_BITS),
         .DEPTH      (LINE_WORDS)
      ) u_line_store (
         .clock        (clock),
         .enable       (step),
         .write_enable (is_write_store && item.resp_valid),
         .address      (store_address),
         .write_data   (item.resp_word),
         .read_data    (store_data[k])
      );
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_minus_one_ff <= vlb_pkg::WIDTH_RESET;
         write_row_ff       <= '0;
         write_column_ff    <= '0;
         write_pointer_ff   <= '0;
         read_pointer_ff    <= '0;
         word_phase_ff      <= vlb_pkg::PHASE_FIRST;
         store_select_ff    <= '0;
         pixel_select_ff    <= '0;
         fill_count_ff      <= '0;
         fetch_state_ff     <= vlb_pkg::FETCH_IDLE;
         request_address_ff <= '0;
         request_pending_ff <= 1'b0;
         response_accept_ff <= 1'b0;
         pixel_ff           <= '0;
      end else begin
         if (csr_write_enable) begin
            width_minus_one_ff <= csr_write_data;
         end
         if (step) begin
            write_row_ff       <= write_row_in;
            write_column_ff    <= write_column_in;
            write_pointer_ff   <= write_pointer_in;
            read_pointer_ff    <= read_pointer_in;
            word_phase_ff      <= word_phase_in;
            store_select_ff    <= vlb_pkg::NUM_LINE_STORES'(1) <<
                                  read_pointer_ff[PTR_BITS-1 -: vlb_pkg::STORE_SEL_BITS];
            pixel_select_ff    <= word_phase_ff;
            fill_count_ff      <= fill_count_in;
            fetch_state_ff     <= fetch_state_in;
            request_address_ff <= request_address_in;
            request_pending_ff <= request_pending_in;
            response_accept_ff <= response_accept_in;
            pixel_ff           <= pixel_in;
         end
      end
   end

endmodule
